[rtl/placement_grid_move_engine_defines.svh]
// Assertion macros shared by the placement grid move engine files.
`ifndef PLACEMENT_GRID_MOVE_ENGINE_DEFINES_SVH
`define PLACEMENT_GRID_MOVE_ENGINE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PGME_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define PGME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/pgme_pkg.sv]
package pgme_pkg;

   // Grid and module capacity
   localparam int MaxRows    = 64;
   localparam int MaxCols    = 64;
   localparam int MaxModules = 1024;
   localparam int CellCount  = MaxRows * MaxCols;
   localparam int CellAw     = $clog2(CellCount);
   localparam int RowW       = $clog2(MaxRows);
   localparam int ColW       = $clog2(MaxCols);
   localparam int ModW       = $clog2(MaxModules);

   // Fixed field widths
   localparam int DimW   = 7;
   localparam int McW    = 11;
   localparam int CodeW  = 11;
   localparam int CntW   = 13;
   localparam int RandW  = 31;
   localparam int OpW    = 3;
   localparam int StatW  = 2;
   localparam int AddrW  = 4;
   localparam int DataW  = 32;
   localparam int StepW  = $clog2(RandW);

   // Operation codes
   localparam logic [OpW-1:0] OpLoadCell  = 3'd0;
   localparam logic [OpW-1:0] OpLoadCoord = 3'd1;
   localparam logic [OpW-1:0] OpSwap      = 3'd2;
   localparam logic [OpW-1:0] OpCount     = 3'd3;
   localparam logic [OpW-1:0] OpPick      = 3'd4;

   // Result status codes
   localparam logic [StatW-1:0] StDone    = 2'd0;
   localparam logic [StatW-1:0] StReject  = 2'd1;
   localparam logic [StatW-1:0] StNoEmpty = 2'd2;

   // Register indexes
   localparam logic [1:0] RegRows  = 2'd0;
   localparam logic [1:0] RegCols  = 2'd1;
   localparam logic [1:0] RegCount = 2'd2;
   localparam logic [1:0] RegEmpty = 2'd3;

   // Remainder unit status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/placement_grid_move_engine.sv]
// Placement grid move engine.
// Input channel req_*: one operation per transfer (load cell, load module
// coordinates, swap two modules, count empty cells, pick a move). Result
// channel rsp_*: exactly one result transfer per operation. Registers
// grid_rows, grid_cols, module_count and empty_code sit on the APB port at
// byte addresses 0, 4, 8 and 12; write them only while the engine is idle.
// One operation at a time: req_stall stays high from the accepted transfer
// until its result has been taken. Count scans the active grid with one
// grid memory read per cycle. Pick runs that scan, then two 31-step
// remainder passes of the shared remainder unit (the second only when the
// module count is nonzero), then a second scan; it skips the passes and
// the second scan when no cell is empty.
// Reset restores the registers to 64, 64, 1024 and -1 and idles the engine;
// grid and coordinate memories hold garbage until loaded. While the receiver
// stalls, the result holds on rsp_* and no new operation is taken.
`include "placement_grid_move_engine_defines.svh"

module placement_grid_move_engine
   import pgme_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OpW-1:0]          req_operation,
   input  logic [ModW-1:0]         req_module_a,
   input  logic [ModW-1:0]         req_module_b,
   input  logic [RowW-1:0]         req_row_in,
   input  logic [ColW-1:0]         req_col_in,
   input  logic signed [CodeW-1:0] req_cell_value,
   input  logic [RandW-1:0]        req_rand_first,
   input  logic [RandW-1:0]        req_rand_second,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [StatW-1:0]        rsp_status,
   output logic [ModW-1:0]         rsp_module_out,
   output logic [RowW-1:0]         rsp_row_out,
   output logic [ColW-1:0]         rsp_col_out,
   output logic [CntW-1:0]         rsp_empty_count,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [AddrW-1:0]        paddr,
   input  logic [DataW-1:0]        pwdata,
   output logic [DataW-1:0]        prdata,
   output logic                    pready
);

   localparam int StW = 5;
   localparam logic [StW-1:0] StateIdle  = 5'd0;
   localparam logic [StW-1:0] StateLoad  = 5'd1;
   localparam logic [StW-1:0] StateCoord = 5'd2;
   localparam logic [StW-1:0] StateCnt   = 5'd3;
   localparam logic [StW-1:0] StateDiv1  = 5'd4;
   localparam logic [StW-1:0] StateDiv2  = 5'd5;
   localparam logic [StW-1:0] StateFind  = 5'd6;
   localparam logic [StW-1:0] StateSwA   = 5'd7;
   localparam logic [StW-1:0] StateSwB   = 5'd8;
   localparam logic [StW-1:0] StateSwC   = 5'd9;
   localparam logic [StW-1:0] StateSwD   = 5'd10;
   localparam logic [StW-1:0] StateSwE   = 5'd11;
   localparam logic [StW-1:0] StateSwF   = 5'd12;
   localparam logic [StW-1:0] StateSwG   = 5'd13;
   localparam logic [StW-1:0] StateSwH   = 5'd14;
   localparam logic [StW-1:0] StateSwI   = 5'd15;
   localparam logic [StW-1:0] StateOut   = 5'd16;

   // Configuration registers
   logic [DimW-1:0]  rows_cfg_ff;
   logic [DimW-1:0]  cols_cfg_ff;
   logic [McW-1:0]   mc_cfg_ff;
   logic [CodeW-1:0] empty_ff;
   logic [DimW-1:0]  rows_act;
   logic [DimW-1:0]  cols_act;
   logic [McW-1:0]   mc_act;
   logic             cfg_wr;

   // Sequencer and latched request
   logic [StW-1:0]   state_ff;
   logic [OpW-1:0]   op_ff;
   logic [ModW-1:0]  ma_ff;
   logic [ModW-1:0]  mb_ff;
   logic [RowW-1:0]  row_ff;
   logic [ColW-1:0]  col_ff;
   logic [CodeW-1:0] val_ff;
   logic [RandW-1:0] r1_ff;
   logic [RandW-1:0] r2_ff;
   logic             launch_ff;

   // Result registers
   logic [StatW-1:0] status_ff;
   logic [ModW-1:0]  mod_ff;
   logic [RowW-1:0]  row_o_ff;
   logic [ColW-1:0]  col_o_ff;
   logic [CntW-1:0]  cnt_ff;

   // Scan pipeline
   logic [DimW-1:0]   scan_r_ff;
   logic [DimW-1:0]   scan_c_ff;
   logic [CellAw-1:0] scan_idx_ff;
   logic              chk_ff;
   logic [RowW-1:0]   chk_r_ff;
   logic [ColW-1:0]   chk_c_ff;
   logic [CntW-1:0]   seen_ff;
   logic [CntW-1:0]   target_ff;
   logic              scan_st;
   logic              issue;
   logic              hit;
   logic              scan_end;

   // Swap work registers
   logic [RowW-1:0]   a_r_ff;
   logic [ColW-1:0]   a_c_ff;
   logic [RowW-1:0]   b_r_ff;
   logic [ColW-1:0]   b_c_ff;
   logic [CellAw-1:0] ia_ff;
   logic [CellAw-1:0] ib_ff;
   logic [CodeW-1:0]  va_ff;
   logic              swap_ok;

   // Index multiplier
   logic [RowW-1:0]   mul_r;
   logic [ColW-1:0]   mul_c;
   logic [CntW-1:0]   mul_sum;
   logic [CellAw-1:0] mul_idx;

   // Memories
   logic [CodeW-1:0]      cell_mem [CellCount];
   logic [CodeW-1:0]      cell_rd_ff;
   logic [CellAw-1:0]     cell_ra;
   logic                  cell_we;
   logic [CellAw-1:0]     cell_wa;
   logic [CodeW-1:0]      cell_wd;
   logic [RowW+ColW-1:0]  crd_mem [MaxModules];
   logic [RowW+ColW-1:0]  crd_rd_ff;
   logic [ModW-1:0]       crd_ra;
   logic                  crd_we;
   logic [ModW-1:0]       crd_wa;
   logic [RowW+ColW-1:0]  crd_wd;

   // Remainder unit
   logic               div_start;
   logic [RandW-1:0]   div_dvd;
   logic [CntW-1:0]    div_dvs;
   div_stat_type       div_stat;
   logic [CntW-1:0]    div_rem;

   logic req_xfer;
   logic rsp_xfer;

   assign req_stall = (state_ff != StateIdle);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == StateOut);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // Clamp geometry to the grid capacity
   assign rows_act = (rows_cfg_ff > DimW'(MaxRows)) ? DimW'(MaxRows) : rows_cfg_ff;
   assign cols_act = (cols_cfg_ff > DimW'(MaxCols)) ? DimW'(MaxCols) : cols_cfg_ff;
   assign mc_act   = (mc_cfg_ff > McW'(MaxModules)) ? McW'(MaxModules) : mc_cfg_ff;

   // Register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= DimW'(64);
         cols_cfg_ff <= DimW'(64);
         mc_cfg_ff   <= McW'(1024);
         empty_ff    <= '1;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            RegRows:  rows_cfg_ff <= pwdata[DimW-1:0];
            RegCols:  cols_cfg_ff <= pwdata[DimW-1:0];
            RegCount: mc_cfg_ff   <= pwdata[McW-1:0];
            RegEmpty: empty_ff    <= pwdata[CodeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegRows:  prdata = DataW'(rows_cfg_ff);
         RegCols:  prdata = DataW'(cols_cfg_ff);
         RegCount: prdata = DataW'(mc_cfg_ff);
         RegEmpty: prdata = DataW'(empty_ff);
         default:  prdata = '0;
      endcase
   end

   // Shared index multiplier: row * cols + col
   always_comb begin
      case (state_ff)
         StateSwD: begin
            mul_r = a_r_ff;
            mul_c = a_c_ff;
         end
         StateSwE: begin
            mul_r = b_r_ff;
            mul_c = b_c_ff;
         end
         default: begin
            mul_r = row_ff;
            mul_c = col_ff;
         end
      endcase
   end
   assign mul_sum = CntW'(CntW'(mul_r) * CntW'(cols_act)) + CntW'(mul_c);
   assign mul_idx = mul_sum[CellAw-1:0];

   // Scan control: one cell read issued per cycle, compared in the cycle after
   assign scan_st  = (state_ff == StateCnt) || (state_ff == StateFind);
   assign issue    = scan_st && (scan_r_ff < rows_act) && (cols_act != '0);
   assign hit      = chk_ff && (cell_rd_ff == empty_ff);
   assign scan_end = !issue && !chk_ff;

   assign swap_ok = ({1'b0, a_r_ff} < rows_act) && ({1'b0, a_c_ff} < cols_act) &&
                    ({1'b0, b_r_ff} < rows_act) && ({1'b0, b_c_ff} < cols_act);

   // Memory port selection
   always_comb begin
      cell_ra = scan_idx_ff;
      cell_we = 1'b0;
      cell_wa = mul_idx;
      cell_wd = val_ff;
      crd_ra  = ma_ff;
      crd_we  = 1'b0;
      crd_wa  = ma_ff;
      crd_wd  = {row_ff, col_ff};
      case (state_ff)
         StateLoad: begin
            cell_we = ({1'b0, row_ff} < rows_act) && ({1'b0, col_ff} < cols_act);
         end
         StateCoord: begin
            crd_we = 1'b1;
         end
         StateSwB: begin
            crd_ra = mb_ff;
         end
         StateSwE: begin
            cell_ra = ia_ff;
         end
         StateSwF: begin
            cell_ra = ib_ff;
         end
         StateSwG: begin
            cell_we = 1'b1;
            cell_wa = ia_ff;
            cell_wd = cell_rd_ff;
         end
         StateSwH: begin
            cell_we = 1'b1;
            cell_wa = ib_ff;
            cell_wd = va_ff;
            crd_we  = 1'b1;
            crd_wd  = {b_r_ff, b_c_ff};
         end
         StateSwI: begin
            crd_we = 1'b1;
            crd_wa = mb_ff;
            crd_wd = {a_r_ff, a_c_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rd_ff <= cell_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (crd_we) begin
         crd_mem[crd_wa] <= crd_wd;
      end
      crd_rd_ff <= crd_mem[crd_ra];
   end

   // Remainder unit operands
   assign div_start = launch_ff;
   assign div_dvd   = (state_ff == StateDiv1) ? r2_ff : r1_ff;
   assign div_dvs   = (state_ff == StateDiv1) ? cnt_ff : CntW'(mc_act);

   pgme_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StateIdle;
         launch_ff <= 1'b0;
         chk_ff    <= 1'b0;
      end else begin
         launch_ff <= 1'b0;
         chk_ff    <= issue;
         case (state_ff)
            StateIdle: begin
               if (req_xfer) begin
                  case (req_operation)
                     OpLoadCell:  state_ff <= StateLoad;
                     OpLoadCoord: state_ff <= StateCoord;
                     OpSwap: begin
                        if (req_module_a == req_module_b) begin
                           state_ff <= StateOut;
                        end else begin
                           state_ff <= StateSwA;
                        end
                     end
                     OpCount, OpPick: state_ff <= StateCnt;
                     default: state_ff <= StateOut;
                  endcase
               end
            end
            StateLoad, StateCoord: state_ff <= StateOut;
            StateCnt: begin
               if (scan_end) begin
                  if (op_ff == OpPick && cnt_ff != '0) begin
                     state_ff  <= StateDiv1;
                     launch_ff <= 1'b1;
                  end else begin
                     state_ff <= StateOut;
                  end
               end
            end
            StateDiv1: begin
               if (div_stat.done) begin
                  if (mc_act != '0) begin
                     state_ff  <= StateDiv2;
                     launch_ff <= 1'b1;
                  end else begin
                     state_ff <= StateFind;
                  end
               end
            end
            StateDiv2: begin
               if (div_stat.done) begin
                  state_ff <= StateFind;
               end
            end
            StateFind: begin
               if ((hit && seen_ff == target_ff) || scan_end) begin
                  state_ff <= StateOut;
               end
            end
            StateSwA: state_ff <= StateSwB;
            StateSwB: state_ff <= StateSwC;
            StateSwC: state_ff <= StateSwD;
            StateSwD: state_ff <= swap_ok ? StateSwE : StateOut;
            StateSwE: state_ff <= StateSwF;
            StateSwF: state_ff <= StateSwG;
            StateSwG: state_ff <= StateSwH;
            StateSwH: state_ff <= StateSwI;
            StateSwI: state_ff <= StateOut;
            StateOut: begin
               if (rsp_xfer) begin
                  state_ff <= StateIdle;
               end
            end
            default: state_ff <= StateIdle;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Advance the scan position
      if (issue) begin
         scan_idx_ff <= scan_idx_ff + CellAw'(1);
         if (scan_c_ff == cols_act - DimW'(1)) begin
            scan_c_ff <= '0;
            scan_r_ff <= scan_r_ff + DimW'(1);
         end else begin
            scan_c_ff <= scan_c_ff + DimW'(1);
         end
      end
      chk_r_ff <= scan_r_ff[RowW-1:0];
      chk_c_ff <= scan_c_ff[ColW-1:0];

      case (state_ff)
         StateIdle: begin
            op_ff       <= req_operation;
            ma_ff       <= req_module_a;
            mb_ff       <= req_module_b;
            row_ff      <= req_row_in;
            col_ff      <= req_col_in;
            val_ff      <= req_cell_value;
            r1_ff       <= req_rand_first;
            r2_ff       <= req_rand_second;
            mod_ff      <= '0;
            row_o_ff    <= '0;
            col_o_ff    <= '0;
            cnt_ff      <= '0;
            seen_ff     <= '0;
            scan_r_ff   <= '0;
            scan_c_ff   <= '0;
            scan_idx_ff <= '0;
            if (req_operation == OpSwap && req_module_a == req_module_b) begin
               status_ff <= StReject;
            end else begin
               status_ff <= StDone;
            end
         end
         StateCnt: begin
            if (hit) begin
               cnt_ff <= cnt_ff + CntW'(1);
            end
            if (scan_end && op_ff == OpPick && cnt_ff == '0) begin
               status_ff <= StNoEmpty;
            end
         end
         StateDiv1: begin
            scan_r_ff   <= '0;
            scan_c_ff   <= '0;
            scan_idx_ff <= '0;
            if (div_stat.done) begin
               target_ff <= div_rem;
            end
         end
         StateDiv2: begin
            if (div_stat.done) begin
               mod_ff <= div_rem[ModW-1:0];
            end
         end
         StateFind: begin
            if (hit) begin
               if (seen_ff == target_ff) begin
                  row_o_ff <= chk_r_ff;
                  col_o_ff <= chk_c_ff;
               end else begin
                  seen_ff <= seen_ff + CntW'(1);
               end
            end
         end
         StateSwB: begin
            a_r_ff <= crd_rd_ff[RowW+ColW-1:ColW];
            a_c_ff <= crd_rd_ff[ColW-1:0];
         end
         StateSwC: begin
            b_r_ff <= crd_rd_ff[RowW+ColW-1:ColW];
            b_c_ff <= crd_rd_ff[ColW-1:0];
         end
         StateSwD: begin
            ia_ff <= mul_idx;
            if (!swap_ok) begin
               status_ff <= StReject;
            end
         end
         StateSwE: begin
            ib_ff <= mul_idx;
         end
         StateSwF: begin
            va_ff <= cell_rd_ff;
         end
         default: ;
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_module_out  = mod_ff;
   assign rsp_row_out     = row_o_ff;
   assign rsp_col_out     = col_o_ff;
   assign rsp_empty_count = cnt_ff;

   `PGME_ASSERT_NEXT(a_accept_blocks, clock, reset, req_xfer, req_stall)
   `PGME_ASSERT_NOW(a_no_empty_clear, clock, reset, rsp_valid && rsp_status == StNoEmpty,
                    rsp_module_out == '0 && rsp_empty_count == '0)
   `PGME_ASSERT_NOW(a_div_launch_idle, clock, reset, div_start, !div_stat.busy)
   `PGME_ASSERT_NOW(a_scan_only_in_scan, clock, reset, chk_ff,
                    state_ff == StateCnt || state_ff == StateFind || state_ff == StateOut)

endmodule

[rtl/pgme_div.sv]
`include "placement_grid_move_engine_defines.svh"

module pgme_div
   import pgme_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RandW-1:0]   dividend,
   input  logic [CntW-1:0]    divisor,
   output div_stat_type       stat,
   output logic [CntW-1:0]    remainder
);

   logic [RandW-1:0] dvd_ff;
   logic [CntW-1:0]  dvs_ff;
   logic [CntW-1:0]  rem_ff;
   logic [CntW-1:0]  rem_in;
   logic [CntW:0]    trial;
   logic [StepW-1:0] step_ff;
   logic             busy_ff;
   logic             done_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[RandW-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = CntW'(trial - {1'b0, dvs_ff});
      end else begin
         rem_in = trial[CntW-1:0];
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == StepW'(RandW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= dividend;
         dvs_ff  <= divisor;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff  <= {dvd_ff[RandW-2:0], 1'b0};
         rem_ff  <= rem_in;
         step_ff <= step_ff + StepW'(1);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

   `PGME_ASSERT_NOW(a_rem_below_divisor, clock, reset, done_ff, rem_ff < dvs_ff)
   `PGME_ASSERT_NOW(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `PGME_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)

endmodule

[verif/tb_top.sv]
module tb_top;
   import pgme_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OpW-1:0] OpSpareLo  = 3'd5;
   localparam logic [OpW-1:0] OpSpareMid = 3'd6;
   localparam logic [OpW-1:0] OpSpareHi  = 3'd7;
   localparam logic [CodeW-1:0] CodeNone = 11'h7FF;
   localparam int IdleLimit = 40000;
   localparam int HoldCycles = 3000;

   typedef struct {
      logic [OpW-1:0]   op;
      logic [ModW-1:0]  ma;
      logic [ModW-1:0]  mb;
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  col;
      logic [CodeW-1:0] val;
      logic [RandW-1:0] r1;
      logic [RandW-1:0] r2;
   } move_req_type;

   typedef struct {
      logic [StatW-1:0] status;
      logic [ModW-1:0]  mod;
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  col;
      logic [CntW-1:0]  cnt;
   } move_rsp_type;

   // Mirror of the grid, the coordinates and the registers; holds the
   // expected results in order.
   class grid_scoreboard;
      logic [CodeW-1:0] cells[CellCount];
      logic [RowW-1:0]  mod_row[MaxModules];
      logic [ColW-1:0]  mod_col[MaxModules];
      int unsigned      rows_reg = 64;
      int unsigned      cols_reg = 64;
      int unsigned      mcount_reg = 1024;
      logic [CodeW-1:0] code_reg = CodeNone;
      move_rsp_type     expected_q[$];
      int               errors = 0;

      function void set_reg(logic [1:0] idx, int unsigned v);
         case (idx)
            RegRows: rows_reg = v & 'h7F;
            RegCols: cols_reg = v & 'h7F;
            RegCount: mcount_reg = v & 'h7FF;
            RegEmpty: code_reg = v[CodeW-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned act_rows();
         return (rows_reg > MaxRows) ? MaxRows : rows_reg;
      endfunction

      function int unsigned act_cols();
         return (cols_reg > MaxCols) ? MaxCols : cols_reg;
      endfunction

      function int unsigned count_empty();
         int unsigned n;
         n = 0;
         for (int unsigned i = 0; i < act_rows() * act_cols(); i++)
            if (cells[i] == code_reg) n++;
         return n;
      endfunction

      // Apply one accepted operation and queue its result.
      function void note(move_req_type t);
         move_rsp_type e;
         int unsigned rs, cs, n, tgt, seen, ia, ib, mc;
         logic [CodeW-1:0] tmp;
         logic [RowW-1:0]  ra, rb;
         logic [ColW-1:0]  ca, cb;
         e = '{default: '0};
         rs = act_rows();
         cs = act_cols();
         case (t.op)
            OpLoadCell: begin
               if (t.row < rs && t.col < cs) cells[t.row * cs + t.col] = t.val;
            end
            OpLoadCoord: begin
               mod_row[t.ma] = t.row;
               mod_col[t.ma] = t.col;
            end
            OpSwap: begin
               e.status = StReject;
               if (t.ma != t.mb) begin
                  ra = mod_row[t.ma]; ca = mod_col[t.ma];
                  rb = mod_row[t.mb]; cb = mod_col[t.mb];
                  if (ra < rs && ca < cs && rb < rs && cb < cs) begin
                     ia = ra * cs + ca;
                     ib = rb * cs + cb;
                     tmp = cells[ia];
                     cells[ia] = cells[ib];
                     cells[ib] = tmp;
                     mod_row[t.ma] = rb; mod_col[t.ma] = cb;
                     mod_row[t.mb] = ra; mod_col[t.mb] = ca;
                     e.status = StDone;
                  end
               end
            end
            OpCount: e.cnt = count_empty();
            OpPick: begin
               n = count_empty();
               if (n == 0) begin
                  e.status = StNoEmpty;
               end else begin
                  mc = (mcount_reg > MaxModules) ? MaxModules : mcount_reg;
                  e.mod = (mc != 0) ? t.r1 % mc : 0;
                  e.cnt = n;
                  tgt = t.r2 % n;
                  seen = 0;
                  for (int unsigned i = 0; i < rs * cs; i++) begin
                     if (cells[i] == code_reg) begin
                        if (seen == tgt) begin
                           e.row = i / cs;
                           e.col = i % cs;
                           break;
                        end
                        seen++;
                     end
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(e);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      // Compare one result transfer with the oldest expectation.
      task check(move_rsp_type r);
         move_rsp_type e;
         if (expected_q.size() == 0) begin
            report("unexpected result", 1, 0);
         end else begin
            e = expected_q.pop_front();
            if (r.status !== e.status) report("status", r.status, e.status);
            if (r.mod !== e.mod) report("module_out", r.mod, e.mod);
            if (r.row !== e.row) report("row_out", r.row, e.row);
            if (r.col !== e.col) report("col_out", r.col, e.col);
            if (r.cnt !== e.cnt) report("empty_count", r.cnt, e.cnt);
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OpW-1:0]          req_operation = '0;
   logic [ModW-1:0]         req_module_a = '0;
   logic [ModW-1:0]         req_module_b = '0;
   logic [RowW-1:0]         req_row_in = '0;
   logic [ColW-1:0]         req_col_in = '0;
   logic signed [CodeW-1:0] req_cell_value = '0;
   logic [RandW-1:0]        req_rand_first = '0;
   logic [RandW-1:0]        req_rand_second = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [StatW-1:0]        rsp_status;
   logic [ModW-1:0]         rsp_module_out;
   logic [RowW-1:0]         rsp_row_out;
   logic [ColW-1:0]         rsp_col_out;
   logic [CntW-1:0]         rsp_empty_count;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [AddrW-1:0]        paddr = '0;
   logic [DataW-1:0]        pwdata = '0;
   logic [DataW-1:0]        prdata;
   logic                    pready;

   grid_scoreboard sb = new();
   int  loaded_mods[$];
   int  burst_left = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;

   placement_grid_move_engine u_top (.*);

   always #2 clock = ~clock;

   // Receiver: long hold on request, else alternate calm and stalling stretches.
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HoldCycles;
      end
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
   end

   // Check each result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check('{rsp_status, rsp_module_out, rsp_row_out, rsp_col_out, rsp_empty_count});
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("[placement_grid_move_engine] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Offer one operation and hold it until the transfer.
   task send_op(move_req_type t);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= t.op;
      req_module_a    <= t.ma;
      req_module_b    <= t.mb;
      req_row_in      <= t.row;
      req_col_in      <= t.col;
      req_cell_value  <= t.val;
      req_rand_first  <= t.r1;
      req_rand_second <= t.r2;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note(t);
      if (t.op == OpLoadCoord) loaded_mods.push_back(t.ma);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(0, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   function move_req_type noise();
      move_req_type t;
      t.op  = $urandom_range(0, 4);
      t.ma  = $urandom;
      t.mb  = $urandom;
      t.row = $urandom;
      t.col = $urandom;
      t.val = $urandom;
      t.r1  = $urandom;
      t.r2  = $urandom;
      return t;
   endfunction

   task op_simple(logic [OpW-1:0] op, int unsigned r1, int unsigned r2);
      move_req_type t;
      t = noise();
      t.op = op; t.r1 = r1; t.r2 = r2;
      send_op(t);
   endtask

   task load_coord(int m, int r, int c);
      move_req_type t;
      t = noise();
      t.op = OpLoadCoord; t.ma = m; t.row = r; t.col = c;
      send_op(t);
   endtask

   task load_cell(int r, int c, int v);
      move_req_type t;
      t = noise();
      t.op = OpLoadCell; t.row = r; t.col = c; t.val = v[CodeW-1:0];
      send_op(t);
   endtask

   task swap_mods(int a, int b);
      move_req_type t;
      t = noise();
      t.op = OpSwap; t.ma = a; t.mb = b;
      send_op(t);
   endtask

   // Wait until the block has returned everything, sender idle.
   task drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task csr_write(logic [1:0] idx, int unsigned v);
      drain();
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= idx * 4; pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   // Write every active cell; each gets the empty code with a chance of empty_pct percent.
   task fill_grid(int empty_pct);
      move_req_type t;
      for (int r = 0; r < sb.act_rows(); r++) begin
         for (int c = 0; c < sb.act_cols(); c++) begin
            t = noise();
            t.op = OpLoadCell; t.row = r; t.col = c;
            t.val = ($urandom_range(0, 99) < empty_pct) ? sb.code_reg
                                                         : $urandom_range(0, 1023);
            send_op(t);
         end
      end
   endtask

   // Random mix of operations; swaps only touch modules with known coordinates.
   task random_ops(int n);
      move_req_type t;
      int unsigned pick, ar, ac;
      for (int i = 0; i < n; i++) begin
         t = noise();
         pick = $urandom_range(0, 99);
         ar = sb.act_rows();
         ac = sb.act_cols();
         if (pick < 25) begin
            t.op = OpLoadCell;
            if ($urandom_range(0, 9) < 7 && ar != 0 && ac != 0) begin
               t.row = $urandom_range(0, ar - 1);
               t.col = $urandom_range(0, ac - 1);
            end
            if ($urandom_range(0, 2) == 0) t.val = sb.code_reg;
         end else if (pick < 40 || loaded_mods.size() < 2) begin
            t.op = OpLoadCoord;
            if ($urandom_range(0, 3) != 0 && ar != 0 && ac != 0) begin
               t.row = $urandom_range(0, ar - 1);
               t.col = $urandom_range(0, ac - 1);
            end
         end else if (pick < 65) begin
            t.op = OpSwap;
            t.ma = loaded_mods[$urandom_range(0, loaded_mods.size() - 1)];
            t.mb = ($urandom_range(0, 7) == 0) ? t.ma
                   : loaded_mods[$urandom_range(0, loaded_mods.size() - 1)];
         end else if (pick < 75) begin
            t.op = OpCount;
         end else if (pick < 95) begin
            t.op = OpPick;
         end else begin
            t.op = $urandom_range(OpSpareLo, OpSpareHi);
         end
         send_op(t);
      end
   endtask

   int phase_cfg[6][5] = '{
      '{3, 5, 7, 0, 40},
      '{1, 1, 1, 1023, 0},
      '{0, 4, 0, 2047, 50},
      '{100, 1, 2047, 5, 30},
      '{3, 3, 1024, 2047, 20},
      '{2, 3, 13, 2047, 10}
   };

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: swaps at the grid corners on the default geometry, unused codes.
      load_coord(0, 0, 0);
      load_coord(1023, 63, 63);
      load_coord(5, 1, 2);
      load_cell(0, 0, 17);
      load_cell(63, 63, 23);
      load_cell(1, 2, CodeNone);
      swap_mods(0, 1023);
      swap_mods(5, 5);
      swap_mods(1023, 5);
      op_simple(OpSpareLo, 0, 0);
      op_simple(OpSpareHi, 0, 0);
      op_simple(OpSpareMid, 0, 0);

      for (int p = 0; p < 6; p++) begin
         csr_write(RegRows, phase_cfg[p][0]);
         csr_write(RegCols, phase_cfg[p][1]);
         csr_write(RegCount, phase_cfg[p][2]);
         csr_write(RegEmpty, phase_cfg[p][3]);
         fill_grid(phase_cfg[p][4]);
         op_simple(OpCount, 0, 0);
         op_simple(OpPick, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
         // Hold the receiver off while the sender keeps offering.
         if (p == 1) hold_seq++;
         random_ops(2);
         // Pause the sender until every result is back.
         if (p == 3) drain();
         random_ops(2);
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("[placement_grid_move_engine] OK");
      else
         $display("[placement_grid_move_engine] ERROR");
      $finish;
   end
endmodule
